// ===== src/ibanm97_pkg.sv =====
// ---------------------------------------------------------------------------
// IBAN mod 97-10 checker package
// Request types, controller command and status types shared by the controller
// and the datapath, and the character folding arithmetic of the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package ibanm97_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned REM_W   = 7;
    localparam int unsigned COUNT_W = 6;

    localparam logic [REM_W-1:0]  REM_OK       = 7'd1;
    localparam logic [REM_W-1:0]  CHECK_BASE   = 7'd98;
    localparam logic [9:0]        MOD_DIVISOR  = 10'd97;
    localparam logic [21:0]       MOD_RECIP    = 22'd2703;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] LETTER_BIAS  = 8'd55;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_in_req;

    typedef struct packed {
        logic [REM_W-1:0] remainder;
        logic [REM_W-1:0] check_digits;
        logic             check_ok;
        logic             bad_char;
        logic             too_short;
    } t_out_req;

    typedef struct packed {
        logic take;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
    endfunction

    // Remainder of a value below 1024 by 97, by reciprocal multiplication.
    function automatic logic [REM_W-1:0] mod97(input logic [9:0] x);
        logic [21:0] p;
        logic [3:0]  q;
        logic [9:0]  r;
        p = 22'(x) * MOD_RECIP;
        q = p[21:18];
        r = x - 10'(q) * MOD_DIVISOR;
        return r[REM_W-1:0];
    endfunction

    // A letter counts as two digits; 100 is congruent to 3 modulo 97.
    function automatic logic [REM_W-1:0] fold_char(input logic [REM_W-1:0]  rem,
                                                   input logic [CHAR_W-1:0] c);
        logic [9:0] x;
        x = 10'd0;
        if (is_digit(c)) begin
            x = 10'(rem) * 10'd10 + 10'(c[3:0]);
        end else if (is_upper(c)) begin
            x = 10'(rem) * 10'd3 + 10'(c - LETTER_BIAS);
        end else begin
            x = 10'(rem);
        end
        return mod97(x);
    endfunction

endpackage

`default_nettype wire

// ===== src/ibanm97_ctrl.sv =====
// ---------------------------------------------------------------------------
// IBAN mod 97-10 checker controller
// Sequences character intake, the replay of the held prefix and the hand-off
// of the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ibanm97_ctrl #(
    parameter int unsigned IDX_W  = 2,
    parameter int unsigned HELD_W = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_last,
    output logic                    o_in_stall,
    input  wire ibanm97_pkg::t_sts  i_sts,
    input  wire logic [HELD_W-1:0]  i_held,
    output ibanm97_pkg::t_cmd       o_cmd,
    output logic [IDX_W-1:0]        o_idx
);
    import ibanm97_pkg::*;

    typedef enum logic [1:0] {
        S_ACCEPT,
        S_REPLAY,
        S_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_ACCEPT: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_REPLAY;
                    n_idx   = '0;
                end
            end
            S_REPLAY: begin
                o_cmd.step = 1'b1;
                if ((HELD_W'(r_idx) + HELD_W'(1)) == i_held) begin
                    n_state = S_FINISH;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_ACCEPT;
                end
            end
            default: begin
                n_state = S_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCEPT;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_idx = r_idx;

endmodule

`default_nettype wire

// ===== src/ibanm97_dp.sv =====
// ---------------------------------------------------------------------------
// IBAN mod 97-10 checker datapath
// Holds the prefix characters, the running remainder, the character count,
// the bad character flag and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ibanm97_dp #(
    parameter int unsigned PREFIX_LEN = 4,
    parameter int unsigned MAX_CHARS  = 34,
    parameter int unsigned IDX_W      = 2,
    parameter int unsigned HELD_W     = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ibanm97_pkg::t_in_req  i_in_data,
    input  wire ibanm97_pkg::t_cmd     i_cmd,
    input  wire logic [IDX_W-1:0]      i_idx,
    output ibanm97_pkg::t_sts          o_sts,
    output logic [HELD_W-1:0]          o_held,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output ibanm97_pkg::t_out_req      o_out_data
);
    import ibanm97_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT  = COUNT_W'(MAX_CHARS);
    localparam logic [COUNT_W-1:0] PREFIX_COUNT = COUNT_W'(PREFIX_LEN);
    localparam logic [COUNT_W-1:0] SHORT_LIMIT  = COUNT_W'(PREFIX_LEN + 1);

    logic [CHAR_W-1:0]  r_prefix [PREFIX_LEN];
    logic [REM_W-1:0]   r_rem;
    logic [COUNT_W-1:0] r_count;
    logic               r_bad;
    logic               r_out_valid;
    t_out_req           r_out;
    logic               w_out_free;
    logic [REM_W-1:0]   w_rem_fold;

    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign o_sts        = '{out_free: w_out_free};
    assign o_held       = (r_count < PREFIX_COUNT) ? HELD_W'(r_count) : HELD_W'(PREFIX_LEN);
    assign w_rem_fold   = fold_char(r_rem, i_in_data.char_code);
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (r_count < COUNT_LIMIT) && (r_count < PREFIX_COUNT)) begin
            r_prefix[r_count[IDX_W-1:0]] <= i_in_data.char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_count <= '0;
            r_bad   <= 1'b0;
        end else if (i_cmd.finish) begin
            r_rem   <= '0;
            r_count <= '0;
            r_bad   <= 1'b0;
        end else if (i_cmd.step) begin
            r_rem <= fold_char(r_rem, r_prefix[i_idx]);
        end else if (i_cmd.take && (r_count < COUNT_LIMIT)) begin
            if (!is_digit(i_in_data.char_code) && !is_upper(i_in_data.char_code)) begin
                r_bad <= 1'b1;
            end
            if (r_count >= PREFIX_COUNT) begin
                r_rem <= w_rem_fold;
            end
            r_count <= r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.remainder    <= r_rem;
            r_out.check_digits <= CHECK_BASE - r_rem;
            r_out.check_ok     <= (r_rem == REM_OK);
            r_out.bad_char     <= r_bad;
            r_out.too_short    <= (r_count < SHORT_LIMIT);
        end
    end

endmodule

`default_nettype wire

// ===== src/iban_mod97_checker_top.sv =====
// ---------------------------------------------------------------------------
// IBAN mod 97-10 checker
// Folds an identifier, one character per request, into a remainder modulo 97
// with the first characters moved to the end, and reports the check result.
//
//   Channel  Direction  Handshake                  Request
//   input    in         i_in_valid / o_in_stall    t_in_req (char_code, last)
//   output   out        o_out_valid / i_out_stall  t_out_req (remainder, flags)
//
// A character is taken every cycle while the input is not stalled. After a
// last character, each held prefix character (PREFIX_LEN for a full identifier)
// is replayed through the fold function, and then the result moves into the
// output register, which waits there while the next identifier streams in.
// Reset is synchronous and active low. The input stalls during replay and through
// the hand-off, which waits while the output register holds an unclaimed result.
// ---------------------------------------------------------------------------
`default_nettype none

module iban_mod97_checker_top #(
    parameter int unsigned PREFIX_LEN = 4,
    parameter int unsigned MAX_CHARS  = 34
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire ibanm97_pkg::t_in_req  i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output ibanm97_pkg::t_out_req      o_out_data
);
    import ibanm97_pkg::*;

    localparam int unsigned IDX_W  = (PREFIX_LEN > 1) ? $clog2(PREFIX_LEN) : 1;
    localparam int unsigned HELD_W = $clog2(PREFIX_LEN + 1);

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [IDX_W-1:0]  w_idx;
    logic [HELD_W-1:0] w_held;

    ibanm97_ctrl #(
        .IDX_W  (IDX_W),
        .HELD_W (HELD_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .i_held     (w_held),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    ibanm97_dp #(
        .PREFIX_LEN (PREFIX_LEN),
        .MAX_CHARS  (MAX_CHARS),
        .IDX_W      (IDX_W),
        .HELD_W     (HELD_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_idx       (w_idx),
        .o_sts       (w_sts),
        .o_held      (w_held),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
